>>> rtl/core/fcc_pkg.sv
// Shared types and constants for the frustum cube cull core.
// No dependencies; imported by fcc_cell and frustum_cube_cull_core.
`default_nettype none

package fcc_pkg;

    // Plane register file
    localparam int REG_COUNT   = 6;
    localparam int CFG_INDEX_W = 3;
    localparam int PLANE_W     = 64;
    localparam int COEF_W      = 16;
    localparam int NORMAL_FRAC = 14;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] IDX_PLANE_NEAR   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] IDX_PLANE_FAR    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] IDX_PLANE_LEFT   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] IDX_PLANE_RIGHT  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] IDX_PLANE_TOP    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] IDX_PLANE_BOTTOM = 3'd5;

    // Control that travels with each word along the chain
    typedef struct packed {
        logic valid;
        logic reject;
    } ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/fcc_cell.sv
// One cell of the culling chain: holds one plane and tests the passing cube.
// Depends on fcc_pkg.
`default_nettype none

module fcc_cell
    import fcc_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int CELL_IDX    = 0
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          advance,
    input  wire logic                          cfg_we,
    input  wire logic [CFG_INDEX_W-1:0]        cfg_index,
    input  wire logic [PLANE_W-1:0]            cfg_data,
    input  wire ctl_t                          in_ctl,
    input  wire logic signed [COORD_WIDTH-1:0] in_cx,
    input  wire logic signed [COORD_WIDTH-1:0] in_cy,
    input  wire logic signed [COORD_WIDTH-1:0] in_cz,
    input  wire logic [COORD_WIDTH-2:0]        in_h,
    output ctl_t                               out_ctl,
    output logic signed [COORD_WIDTH-1:0]      out_cx,
    output logic signed [COORD_WIDTH-1:0]      out_cy,
    output logic signed [COORD_WIDTH-1:0]      out_cz,
    output logic [COORD_WIDTH-2:0]             out_h
);

    localparam int HALF_W = COORD_WIDTH - 1;
    localparam int PROD_W = COORD_WIDTH + COEF_W;
    localparam int SPAN_W = COEF_W + 2 + HALF_W;
    localparam int ACC_W  = COORD_WIDTH + 24;
    localparam logic [CFG_INDEX_W-1:0] MY_INDEX = CFG_INDEX_W'(CELL_IDX);
    localparam bit WRITABLE = (CELL_IDX < REG_COUNT);

    logic [PLANE_W-1:0] plane_reg;

    logic signed [COEF_W-1:0] a_s, b_s, c_s, d_s;
    logic signed [COEF_W:0]   a_ext, b_ext, c_ext;
    logic [COEF_W:0]          abs_a, abs_b, abs_c;
    logic [COEF_W+1:0]        span;

    logic signed [PROD_W-1:0] pa_next, pb_next, pc_next;
    logic [SPAN_W-1:0]        ps_next;
    logic signed [PROD_W-1:0] pa_reg, pb_reg, pc_reg;
    logic [SPAN_W-1:0]        ps_reg;
    logic signed [COEF_W-1:0] pd_reg;

    ctl_t                          ctl1_reg;
    logic signed [COORD_WIDTH-1:0] cx1_reg, cy1_reg, cz1_reg;
    logic [HALF_W-1:0]             h1_reg;

    ctl_t                          ctl2_reg, ctl2_next;
    logic signed [COORD_WIDTH-1:0] cx2_reg, cy2_reg, cz2_reg;
    logic [HALF_W-1:0]             h2_reg;

    logic signed [ACC_W-1:0] far_corner;

    // Plane register, written from the configuration port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_reg <= '0;
        end else if (WRITABLE && cfg_we && (cfg_index == MY_INDEX)) begin
            plane_reg <= cfg_data;
        end
    end

    // Unpack coefficients; |a|+|b|+|c| gives the corner furthest along the normal
    assign a_s   = plane_reg[15:0];
    assign b_s   = plane_reg[31:16];
    assign c_s   = plane_reg[47:32];
    assign d_s   = plane_reg[63:48];
    assign a_ext = {a_s[COEF_W-1], a_s};
    assign b_ext = {b_s[COEF_W-1], b_s};
    assign c_ext = {c_s[COEF_W-1], c_s};
    assign abs_a = a_ext[COEF_W] ? 17'(-a_ext) : 17'(a_ext);
    assign abs_b = b_ext[COEF_W] ? 17'(-b_ext) : 17'(b_ext);
    assign abs_c = c_ext[COEF_W] ? 17'(-c_ext) : 17'(c_ext);
    assign span  = {1'b0, abs_a} + {1'b0, abs_b} + {1'b0, abs_c};

    // Stage 1 products
    assign pa_next = a_s * in_cx;
    assign pb_next = b_s * in_cy;
    assign pc_next = c_s * in_cz;
    assign ps_next = span * in_h;

    // Stage 2: plane distance of the furthest corner, scaled by 2^14
    assign far_corner = ACC_W'(pa_reg) + ACC_W'(pb_reg) + ACC_W'(pc_reg)
                      + ACC_W'(ps_reg) + (ACC_W'(pd_reg) <<< NORMAL_FRAC);

    always_comb begin
        ctl2_next.valid  = ctl1_reg.valid;
        ctl2_next.reject = ctl1_reg.reject | far_corner[ACC_W-1];
    end

    // Control of both stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end else if (advance) begin
            ctl1_reg <= in_ctl;
            ctl2_reg <= ctl2_next;
        end
    end

    // Payload of both stages
    always_ff @(posedge aclk) begin
        if (advance) begin
            pa_reg  <= pa_next;
            pb_reg  <= pb_next;
            pc_reg  <= pc_next;
            ps_reg  <= ps_next;
            pd_reg  <= d_s;
            cx1_reg <= in_cx;
            cy1_reg <= in_cy;
            cz1_reg <= in_cz;
            h1_reg  <= in_h;
            cx2_reg <= cx1_reg;
            cy2_reg <= cy1_reg;
            cz2_reg <= cz1_reg;
            h2_reg  <= h1_reg;
        end
    end

    assign out_ctl = ctl2_reg;
    assign out_cx  = cx2_reg;
    assign out_cy  = cy2_reg;
    assign out_cz  = cz2_reg;
    assign out_h   = h2_reg;

endmodule

`default_nettype wire

>>> rtl/core/frustum_cube_cull_core.sv
// Throughput: one word per cycle unless stalled; each plane cell has a multiply stage
// and an add/compare stage, and the whole chain moves unless the result word is stalled.
// Reset: synchronous, active low; clears all word valids and plane registers.
// Top level of the frustum cube cull core; chain of fcc_cell instances.
// Depends on fcc_pkg and fcc_cell.
`default_nettype none

module frustum_cube_cull_core
    import fcc_pkg::*;
#(
    parameter int PLANE_COUNT = 6,
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [COORD_WIDTH-1:0] s_center_x,
    input  wire logic signed [COORD_WIDTH-1:0] s_center_y,
    input  wire logic signed [COORD_WIDTH-1:0] s_center_z,
    input  wire logic [COORD_WIDTH-2:0]        s_half_size,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_visible,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]        cfg_index,
    input  wire logic [PLANE_W-1:0]            cfg_data
);

    ctl_t                          ctl_chain [PLANE_COUNT+1];
    logic signed [COORD_WIDTH-1:0] cx_chain  [PLANE_COUNT+1];
    logic signed [COORD_WIDTH-1:0] cy_chain  [PLANE_COUNT+1];
    logic signed [COORD_WIDTH-1:0] cz_chain  [PLANE_COUNT+1];
    logic [COORD_WIDTH-2:0]        h_chain   [PLANE_COUNT+1];
    logic                          advance;

    // Whole chain moves unless the result word is stalled
    assign advance = !m_valid || m_ready;
    assign s_ready = advance;

    // Head of the chain
    assign ctl_chain[0].valid  = s_valid;
    assign ctl_chain[0].reject = 1'b0;
    assign cx_chain[0]         = s_center_x;
    assign cy_chain[0]         = s_center_y;
    assign cz_chain[0]         = s_center_z;
    assign h_chain[0]          = s_half_size;

    for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_cell
        fcc_cell #(
            .COORD_WIDTH (COORD_WIDTH),
            .CELL_IDX    (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .cfg_we    (cfg_valid),
            .cfg_index (cfg_index),
            .cfg_data  (cfg_data),
            .in_ctl    (ctl_chain[i]),
            .in_cx     (cx_chain[i]),
            .in_cy     (cy_chain[i]),
            .in_cz     (cz_chain[i]),
            .in_h      (h_chain[i]),
            .out_ctl   (ctl_chain[i+1]),
            .out_cx    (cx_chain[i+1]),
            .out_cy    (cy_chain[i+1]),
            .out_cz    (cz_chain[i+1]),
            .out_h     (h_chain[i+1])
        );
    end

    // Last cell's stage 2 register is the result word
    assign m_valid   = ctl_chain[PLANE_COUNT].valid;
    assign m_visible = !ctl_chain[PLANE_COUNT].reject;
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// Testbench for frustum_cube_cull_core: drives cube words, loads plane registers
// and checks every visibility word against a predictor built into the bench.
// Depends on fcc_pkg and the core RTL only.
`default_nettype none

module tb;
    import fcc_pkg::*;

    localparam int PLANE_COUNT = 6;
    localparam int COORD_WIDTH = 16;
    localparam int CHAIN_DEPTH = 2 * PLANE_COUNT;
    localparam int LIMIT       = 200000;

    // Writes to these indexes must be ignored by the core
    localparam logic [CFG_INDEX_W-1:0] IDX_BEYOND_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] IDX_BEYOND_HI = 3'd7;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                          s_valid     = 1'b0;
    logic                          s_ready;
    logic signed [COORD_WIDTH-1:0] s_center_x  = '0;
    logic signed [COORD_WIDTH-1:0] s_center_y  = '0;
    logic signed [COORD_WIDTH-1:0] s_center_z  = '0;
    logic [COORD_WIDTH-2:0]        s_half_size = '0;
    logic                          m_valid;
    logic                          m_ready     = 1'b0;
    logic                          m_visible;
    logic                          cfg_valid   = 1'b0;
    logic                          cfg_ready;
    logic [CFG_INDEX_W-1:0]        cfg_index   = '0;
    logic [PLANE_W-1:0]            cfg_data    = '0;

    // Bench copy of the plane registers and the next set to load
    logic [PLANE_W-1:0] plane_set  [REG_COUNT];
    logic [PLANE_W-1:0] plane_next [REG_COUNT];

    logic visible_due[$];
    int   mismatches = 0;
    int   cycles     = 0;
    bit   gaps_on    = 1'b1;
    int   sink_hold  = 0;

    frustum_cube_cull_core #(
        .PLANE_COUNT(PLANE_COUNT),
        .COORD_WIDTH(COORD_WIDTH)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_center_x (s_center_x),
        .s_center_y (s_center_y),
        .s_center_z (s_center_z),
        .s_half_size(s_half_size),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_visible  (m_visible),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Visibility of one cube: rejected if any plane has all eight corners behind it
    function automatic logic cube_visible(input logic signed [COORD_WIDTH-1:0] cx,
                                          input logic signed [COORD_WIDTH-1:0] cy,
                                          input logic signed [COORD_WIDTH-1:0] cz,
                                          input logic [COORD_WIDTH-2:0] h);
        longint a, b, c, d, x, y, z, hh;
        int     p, k, behind;
        logic   vis;
        vis = 1'b1;
        hh  = longint'(h);
        for (p = 0; p < PLANE_COUNT; p++) begin
            a = longint'($signed(plane_set[p][15:0]));
            b = longint'($signed(plane_set[p][31:16]));
            c = longint'($signed(plane_set[p][47:32]));
            d = longint'($signed(plane_set[p][63:48]));
            behind = 0;
            for (k = 0; k < 8; k++) begin
                x = longint'(cx) + (k[0] ? hh : -hh);
                y = longint'(cy) + (k[1] ? hh : -hh);
                z = longint'(cz) + (k[2] ? hh : -hh);
                if (a * x + b * y + c * z + d * (longint'(1) << NORMAL_FRAC) < 0)
                    behind++;
            end
            if (behind == 8)
                vis = 1'b0;
        end
        return vis;
    endfunction

    function automatic logic [PLANE_W-1:0] pack_plane(input logic [15:0] a, b, c, d);
        return {d, c, b, a};
    endfunction

    // Random plane: mostly offsets near the origin so both outcomes are common
    function automatic logic [PLANE_W-1:0] rand_plane();
        logic [15:0] d;
        if ($urandom_range(0, 3) == 0)
            d = 16'($urandom);
        else
            d = 16'(int'($urandom_range(0, 6000)) - 3000);
        return pack_plane(16'($urandom), 16'($urandom), 16'($urandom), d);
    endfunction

    // Record each accepted cube word with its predicted visibility
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            visible_due.push_back(cube_visible(s_center_x, s_center_y, s_center_z,
                                               s_half_size));
    end

    // Check each result word against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (visible_due.size() == 0) begin
                $display("%0t: result word with nothing expected, got visible=%0b",
                         $time, m_visible);
                mismatches++;
            end else begin
                logic due;
                due = visible_due.pop_front();
                if (m_visible !== due) begin
                    $display("%0t: visible mismatch, expected %0b, got %0b",
                             $time, due, m_visible);
                    mismatches++;
                end
            end
        end
    end

    // Result sink: random stalls, or a long hold when one is requested
    initial begin : result_sink
        int stall;
        forever begin
            if (sink_hold > 0) begin
                stall     = sink_hold;
                sink_hold = 0;
            end else begin
                stall = gaps_on ? $urandom_range(0, 7) : 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready) && sink_hold == 0);
        end
    end

    // Send one cube word; valid stays up across back-to-back words
    task automatic send_cube(input logic signed [COORD_WIDTH-1:0] cx,
                             input logic signed [COORD_WIDTH-1:0] cy,
                             input logic signed [COORD_WIDTH-1:0] cz,
                             input logic [COORD_WIDTH-2:0] h);
        int gap;
        gap = gaps_on ? $urandom_range(0, 7) : 0;
        cfg_valid <= 1'b0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_center_x  <= cx;
        s_center_y  <= cy;
        s_center_z  <= cz;
        s_half_size <= h;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Mostly small cubes near the origin, some across the full range
    task automatic send_random_cube();
        logic signed [COORD_WIDTH-1:0] cx, cy, cz;
        logic [COORD_WIDTH-2:0]        h;
        if ($urandom_range(0, 9) < 7) begin
            cx = 16'(int'($urandom_range(0, 4000)) - 2000);
            cy = 16'(int'($urandom_range(0, 4000)) - 2000);
            cz = 16'(int'($urandom_range(0, 4000)) - 2000);
            h  = 15'($urandom_range(0, 1500));
        end else begin
            cx = 16'($urandom);
            cy = 16'($urandom);
            cz = 16'($urandom);
            h  = 15'($urandom);
        end
        send_cube(cx, cy, cz, h);
    endtask

    task automatic run_cubes(input int count);
        repeat (count) send_random_cube();
    endtask

    // Register write; caller makes sure the core is idle first
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [PLANE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (idx < REG_COUNT)
            plane_set[idx] = data;
    endtask

    task automatic load_planes();
        logic [CFG_INDEX_W-1:0] idx;
        for (idx = IDX_PLANE_NEAR; idx <= IDX_PLANE_BOTTOM; idx++)
            write_reg(idx, plane_next[idx]);
    endtask

    // Drop valids and wait until every result word is back and the chain is empty
    task automatic settle();
        s_valid   <= 1'b0;
        cfg_valid <= 1'b0;
        @(posedge aclk);
        while (visible_due.size() != 0) @(posedge aclk);
        repeat (CHAIN_DEPTH + 4) @(posedge aclk);
    endtask

    // Cleared planes never reject, even at the coordinate extremes
    task automatic test_cleared_planes();
        send_cube(16'sh8000, 16'sh8000, 16'sh8000, 15'h0000);
        send_cube(16'sh7fff, 16'sh7fff, 16'sh7fff, 15'h7fff);
        send_cube(16'sh0000, 16'sh0000, 16'sh0000, 15'h0000);
        send_cube(16'sh8000, 16'sh7fff, 16'shffff, 15'h4000);
    endtask

    // Writes past the last plane register must not land anywhere
    task automatic test_ignored_index();
        settle();
        write_reg(IDX_BEYOND_LO, '1);
        write_reg(IDX_BEYOND_HI, '1);
        send_cube(16'sh0000, 16'sh0000, 16'sh0000, 15'h0000);
        send_cube(16'sh0100, 16'sh0100, 16'sh0100, 15'h0010);
    endtask

    // Near plane x >= 0: a corner exactly on the plane counts as inside
    task automatic test_touching_corner();
        settle();
        write_reg(IDX_PLANE_NEAR, pack_plane(16'h4000, 16'h0000, 16'h0000, 16'h0000));
        send_cube(-16'sd5, 16'sh0000, 16'sh0000, 15'd5);
        send_cube(-16'sd6, 16'sh0000, 16'sh0000, 15'd5);
        send_cube(-16'sd1, 16'sh0000, 16'sh0000, 15'd0);
        send_cube(16'sh0000, 16'sh0000, 16'sh0000, 15'd0);
        send_cube(16'sh8000, 16'sh7fff, 16'sh8000, 15'h7fff);
    endtask

    // Each register alone rejects cubes beyond z = 100
    task automatic test_each_plane();
        logic [CFG_INDEX_W-1:0] idx;
        for (idx = IDX_PLANE_NEAR; idx <= IDX_PLANE_BOTTOM; idx++) begin
            settle();
            if (idx == IDX_PLANE_FAR)
                write_reg(IDX_PLANE_NEAR, '0);
            else if (idx != IDX_PLANE_NEAR)
                write_reg(idx - 1'b1, '0);
            write_reg(idx, pack_plane(16'h0000, 16'h0000, 16'hc000, 16'd100));
            send_cube(16'sh0000, 16'sh0000, 16'sd0, 15'd50);
            send_cube(16'sh0000, 16'sh0000, 16'sd200, 15'd50);
        end
    endtask

    // Extreme register contents in every plane
    task automatic test_extreme_planes();
        int i;
        settle();
        for (i = 0; i < REG_COUNT; i++) plane_next[i] = '1;
        load_planes();
        run_cubes(100);
        settle();
        for (i = 0; i < REG_COUNT; i++) plane_next[i] = {4{16'h8000}};
        load_planes();
        run_cubes(100);
        settle();
        for (i = 0; i < REG_COUNT; i++) plane_next[i] = {4{16'h7fff}};
        load_planes();
        run_cubes(100);
    endtask

    // Axis-aligned box frustum, |x|, |y|, |z| <= 1000
    task automatic test_box_frustum();
        settle();
        plane_next[IDX_PLANE_NEAR]   = pack_plane(16'h0000, 16'h0000, 16'h4000, 16'd1000);
        plane_next[IDX_PLANE_FAR]    = pack_plane(16'h0000, 16'h0000, 16'hc000, 16'd1000);
        plane_next[IDX_PLANE_LEFT]   = pack_plane(16'h4000, 16'h0000, 16'h0000, 16'd1000);
        plane_next[IDX_PLANE_RIGHT]  = pack_plane(16'hc000, 16'h0000, 16'h0000, 16'd1000);
        plane_next[IDX_PLANE_TOP]    = pack_plane(16'h0000, 16'hc000, 16'h0000, 16'd1000);
        plane_next[IDX_PLANE_BOTTOM] = pack_plane(16'h0000, 16'h4000, 16'h0000, 16'd1000);
        load_planes();
        run_cubes(150);
    endtask

    // Random plane sets, some planes left cleared
    task automatic test_random_planes();
        int i;
        repeat (4) begin
            settle();
            for (i = 0; i < REG_COUNT; i++)
                plane_next[i] = ($urandom_range(0, 4) == 0) ? '0 : rand_plane();
            load_planes();
            run_cubes(100);
        end
    endtask

    // Sink holds off for a long stretch while words keep coming: chain fills up
    task automatic test_backpressure();
        settle();
        gaps_on   = 1'b0;
        sink_hold = 300;
        run_cubes(150);
        gaps_on   = 1'b1;
    endtask

    // A stretch with no idle cycles on either side
    task automatic test_no_gaps();
        settle();
        gaps_on = 1'b0;
        run_cubes(150);
        gaps_on = 1'b1;
    endtask

    // Test sequence
    initial begin : stimulus
        int i;
        for (i = 0; i < REG_COUNT; i++) plane_set[i] = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_cleared_planes();
        test_ignored_index();
        test_touching_corner();
        test_each_plane();
        test_extreme_planes();
        test_box_frustum();
        test_random_planes();
        test_backpressure();
        test_no_gaps();
        settle();
        if (mismatches == 0 && visible_due.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
